[rtl/kbfr_pkg.sv]
// kbfr_pkg: shared types and constants of the keypad bus frame receiver
// no dependencies; imported by kbfr_framer, kbfr_result_fifo, the top level and the testbench

package kbfr_pkg;

	// input item kinds
	localparam logic [1:0] KIND_START   = 2'd0;
	localparam logic [1:0] KIND_BYTE    = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	// result kinds
	localparam logic OUT_TX      = 1'b0;
	localparam logic OUT_OUTCOME = 1'b1;

	// frame classes
	localparam logic [1:0] CLASS_NONE  = 2'd0;
	localparam logic [1:0] CLASS_KEY   = 2'd1;
	localparam logic [1:0] CLASS_TYPED = 2'd2;

	// outcome status codes
	localparam logic [1:0] ST_ACCEPTED   = 2'd0;
	localparam logic [1:0] ST_NO_REPLY   = 2'd1;
	localparam logic [1:0] ST_WRONG_ADDR = 2'd2;
	localparam logic [1:0] ST_BAD_SUM    = 2'd3;

	// protocol constants
	localparam logic [7:0] REQ_BYTE   = 8'hF6;
	localparam logic [7:0] TYPED_CODE = 8'h87;
	localparam logic [7:0] KEY_MAX    = 8'd16;
	localparam logic [6:0] FIXED_LEN  = 7'd9;
	localparam logic [6:0] KEY_EXTRA  = 7'd2;

	// framing phase, one-hot
	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_FIRST  = 4'b0010,
		PH_SECOND = 4'b0100,
		PH_BODY   = 4'b1000
	} phase_t;

	// one result item
	typedef struct packed {
		logic       out_kind;
		logic [7:0] tx_byte;
		logic [1:0] frame_class;
		logic [7:0] type_code;
		logic [6:0] frame_len;
		logic [1:0] status;
		logic       last;
	} result_t;

	// write strobes from the framer into the result queue
	typedef struct packed {
		logic push0;
		logic push1;
	} push_t;

endpackage

[rtl/kbfr_framer.sv]
// kbfr_framer: input register, framing state and the per-item result logic
// depends on kbfr_pkg

module kbfr_framer #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [7:0]        value,
	input  logic [4:0]        target_address,
	input  logic              queue_room,
	output kbfr_pkg::push_t   push,
	output kbfr_pkg::result_t res0,
	output kbfr_pkg::result_t res1
);
	import kbfr_pkg::*;

	localparam logic [6:0] BUF_LIMIT = 7'(BUFFER_BYTES);

	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] value_s1;
	logic [4:0] addr_s1;
	logic       fire;

	phase_t     phase_q, phase_n;
	logic [4:0] addr_q, addr_n;
	logic [6:0] count_q, count_n;
	logic [6:0] exp_q, exp_n;
	logic [7:0] first_q, first_n;
	logic [7:0] second_q, second_n;
	logic [7:0] sum_q, sum_n;
	logic [7:0] newest_q, newest_n;

	logic       tmo;
	logic [7:0] take_sum;
	logic [6:0] take_cnt;
	logic       emit_start;
	logic       emit_noreply;
	logic       do_finish;
	logic [7:0] chk_sum;
	logic [7:0] chk_byte;
	logic [7:0] calc;
	logic       addr_bad;
	logic       sum_bad;

	// input register: holds while the result queue lacks room for two
	assign fire     = valid_s1 & queue_room;
	assign in_stall = valid_s1 & ~queue_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (in_valid & ~in_stall) | in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1  <= kind;
			value_s1 <= value;
			addr_s1  <= target_address;
		end
	end

	// next framing state
	assign tmo      = (kind_s1 == KIND_TIMEOUT);
	assign take_sum = sum_q + newest_q;
	assign take_cnt = count_q + 7'd1;

	always_comb begin
		phase_n      = phase_q;
		addr_n       = addr_q;
		count_n      = count_q;
		exp_n        = exp_q;
		first_n      = first_q;
		second_n     = second_q;
		sum_n        = sum_q;
		newest_n     = newest_q;
		emit_start   = 1'b0;
		emit_noreply = 1'b0;
		do_finish    = 1'b0;
		if (kind_s1 == KIND_START) begin
			addr_n     = addr_s1;
			count_n    = '0;
			exp_n      = '0;
			first_n    = '0;
			second_n   = '0;
			sum_n      = '0;
			newest_n   = '0;
			phase_n    = PH_FIRST;
			emit_start = 1'b1;
		end else if (kind_s1 == KIND_BYTE || kind_s1 == KIND_TIMEOUT) begin
			priority if ((phase_q == PH_FIRST || phase_q == PH_SECOND) && tmo) begin
				phase_n      = PH_IDLE;
				emit_noreply = 1'b1;
			end else if (phase_q == PH_FIRST) begin
				first_n  = value_s1;
				newest_n = value_s1;
				sum_n    = '0;
				count_n  = 7'd1;
				phase_n  = PH_SECOND;
			end else if (phase_q == PH_SECOND) begin
				second_n = value_s1;
				sum_n    = take_sum;
				newest_n = value_s1;
				count_n  = take_cnt;
				phase_n  = PH_BODY;
				if (value_s1 == TYPED_CODE) begin
					exp_n = FIXED_LEN;
				end else if (value_s1 <= KEY_MAX) begin
					exp_n     = value_s1[6:0] + KEY_EXTRA;
					do_finish = (value_s1 == 8'd0);
				end else begin
					exp_n = '0;
				end
			end else if (phase_q == PH_BODY) begin
				if (exp_q == 7'd0) begin
					// open frame: ends on timeout or a full buffer
					if (tmo) begin
						do_finish = 1'b1;
					end else begin
						sum_n     = take_sum;
						newest_n  = value_s1;
						count_n   = take_cnt;
						do_finish = (take_cnt >= BUF_LIMIT);
					end
				end else begin
					// fixed length: a timeout stands for a zero byte
					sum_n     = take_sum;
					newest_n  = tmo ? 8'd0 : value_s1;
					count_n   = take_cnt;
					do_finish = (take_cnt >= exp_q);
				end
			end else begin
				phase_n = phase_q;
			end
		end
		if (do_finish) begin
			phase_n = PH_IDLE;
		end
	end

	// frame checks on the updated state
	always_comb begin
		if (count_n == 7'd2) begin
			chk_sum  = first_n + second_n;
			chk_byte = second_n;
		end else begin
			chk_sum  = sum_n;
			chk_byte = newest_n;
		end
	end

	assign calc     = 8'd0 - chk_sum;
	assign addr_bad = (first_n[5:0] != {1'b0, addr_n});
	assign sum_bad  = (calc != chk_byte);

	// results of this transaction
	always_comb begin
		res0 = '0;
		res1 = '0;
		push = '0;
		if (fire) begin
			if (emit_start) begin
				res0.out_kind = OUT_TX;
				res0.tx_byte  = REQ_BYTE;
				res1.out_kind = OUT_TX;
				res1.tx_byte  = {3'b000, addr_s1};
				res1.last     = 1'b1;
				push.push0    = 1'b1;
				push.push1    = 1'b1;
			end else if (emit_noreply) begin
				res0.out_kind = OUT_OUTCOME;
				res0.status   = ST_NO_REPLY;
				res0.last     = 1'b1;
				push.push0    = 1'b1;
			end else if (do_finish) begin
				if (addr_bad || sum_bad) begin
					res0.out_kind  = OUT_OUTCOME;
					res0.frame_len = count_n;
					res0.status    = addr_bad ? ST_WRONG_ADDR : ST_BAD_SUM;
					res0.last      = 1'b1;
					push.push0     = 1'b1;
				end else begin
					res0.out_kind  = OUT_TX;
					res0.tx_byte   = first_n;
					res1.out_kind  = OUT_OUTCOME;
					res1.frame_len = count_n;
					res1.status    = ST_ACCEPTED;
					res1.last      = 1'b1;
					if (second_n <= KEY_MAX) begin
						res1.frame_class = CLASS_KEY;
					end else begin
						res1.frame_class = CLASS_TYPED;
						res1.type_code   = second_n;
					end
					push.push0 = 1'b1;
					push.push1 = 1'b1;
				end
			end
		end
	end

	// framing state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			addr_q   <= '0;
			count_q  <= '0;
			exp_q    <= '0;
			first_q  <= '0;
			second_q <= '0;
			sum_q    <= '0;
			newest_q <= '0;
		end else if (fire) begin
			phase_q  <= phase_n;
			addr_q   <= addr_n;
			count_q  <= count_n;
			exp_q    <= exp_n;
			first_q  <= first_n;
			second_q <= second_n;
			sum_q    <= sum_n;
			newest_q <= newest_n;
		end
	end

	// second result never goes without the first
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.push1 |-> push.push0)
		else $error("second result pushed without first");

	// stall only with a held item
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("stall with empty input register");

	// a start always waits for the first reply byte
	a_start_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && kind_s1 == KIND_START) |=> phase_q == PH_FIRST)
		else $error("start did not enter first-byte phase");

endmodule

[rtl/kbfr_result_fifo.sv]
// kbfr_result_fifo: four-entry result queue, two writes and one read per cycle
// depends on kbfr_pkg

module kbfr_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  kbfr_pkg::push_t   push,
	input  kbfr_pkg::result_t res0,
	input  kbfr_pkg::result_t res1,
	output logic              queue_room,
	output logic              out_valid,
	input  logic              out_stall,
	output kbfr_pkg::result_t head
);
	import kbfr_pkg::*;

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	result_t       mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	// room for a full pair of results
	assign queue_room = (count_q <= CW'(DEPTH - 2));
	assign out_valid  = (count_q != '0);
	assign pop        = out_valid & ~out_stall;
	assign head       = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_ptr_q] <= res0;
		end
		if (push.push1) begin
			mem_q[wr_ptr_q + PW'(1)] <= res1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.push0) + PW'(push.push1);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q  <= count_q + CW'(push.push0) + CW'(push.push1) - CW'(pop);
		end
	end

	// never overfilled
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result queue overflow");

	// writes only with room reported
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.push0 |-> queue_room)
		else $error("push without room");

	// a lone read drops the count by one
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push.push0) |=> count_q == $past(count_q) - CW'(1))
		else $error("fill count wrong after read");

endmodule

[rtl/keypad_bus_frame_receiver_top.sv]
// keypad_bus_frame_receiver_top: host side of a keypad data request
// depends on kbfr_pkg, kbfr_framer and kbfr_result_fifo

// The block takes one input transaction per clock cycle while in_stall is
// low. Each item is registered, then processed in the input register by short
// framing logic that writes zero, one or two results into a four-entry result
// queue, whose head drives the output. The output delivers one result per
// cycle while out_stall is low, so items that yield two results (a start
// request, an accepted frame) are limited by the output rate, all others pass
// at one item per cycle. Input stall rises while the input register holds an
// item and the queue has fewer than two free entries. A start while a frame
// is in progress drops that frame.

module keypad_bus_frame_receiver_top #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [7:0] value,
	input  logic [4:0] target_address,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       out_kind,
	output logic [7:0] tx_byte,
	output logic [1:0] frame_class,
	output logic [7:0] type_code,
	output logic [6:0] frame_len,
	output logic [1:0] status,
	output logic       last
);
	import kbfr_pkg::*;

	push_t   push;
	result_t res0;
	result_t res1;
	result_t head;
	logic    queue_room;

	// framing and result generation
	kbfr_framer #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_framer (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.value         (value),
		.target_address(target_address),
		.queue_room    (queue_room),
		.push          (push),
		.res0          (res0),
		.res1          (res1)
	);

	// result queue toward the output channel
	kbfr_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res0      (res0),
		.res1      (res1),
		.queue_room(queue_room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	// output fields
	assign out_kind    = head.out_kind;
	assign tx_byte     = head.tx_byte;
	assign frame_class = head.frame_class;
	assign type_code   = head.type_code;
	assign frame_len   = head.frame_len;
	assign status      = head.status;
	assign last        = head.last;

endmodule

[verif/tb_keypad_bus_frame_receiver_top.sv]
// tb_keypad_bus_frame_receiver_top: self-checking testbench of the keypad bus frame receiver
// predicts request bytes and frame outcomes from the accepted input transactions
// depends on kbfr_pkg and keypad_bus_frame_receiver_top

`timescale 1ns / 100ps

module tb_keypad_bus_frame_receiver_top;
	import kbfr_pkg::*;

	localparam int FRAME_BUFFER = 64;
	localparam int QUIET_LIMIT  = 2000;
	localparam int LONG_HOLD    = 300;
	localparam int TAIL_CYCLES  = 12;
	localparam int ITEM_TARGET  = 1300;

	// input kind that the block ignores
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_pattern_t;
	typedef enum {STYLE_SILENT, STYLE_KEY, STYLE_TYPED, STYLE_OPEN} frame_style_t;

	// tracks the request and framing state and holds the results still to come
	class kbfr_reply_tracker #(int BUF_BYTES = 64);
		result_t     awaited_results[$];
		int unsigned mismatches, n_checked, n_requests;
		int unsigned n_key, n_typed, n_no_reply, n_wrong_addr, n_bad_sum;
		phase_t      ph;
		logic [4:0]  query_addr;
		logic [6:0]  byte_cnt, frame_target;
		logic [7:0]  first_b, second_b, sum_head, newest_b;

		function new();
			ph         = PH_IDLE;
			query_addr = '0;
			byte_cnt   = '0;
			frame_target = '0;
			first_b    = '0;
			second_b   = '0;
			sum_head   = '0;
			newest_b   = '0;
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= 50)
				$display("mismatch at %0t ns: %s", $time, msg);
			else if (mismatches == 51)
				$display("further mismatches are counted but not printed");
		endtask

		function void push_result(logic ok, logic [7:0] tx, logic [1:0] cls,
				logic [7:0] code, logic [6:0] len, logic [1:0] st, logic fin);
			result_t r;
			r = '{ok, tx, cls, code, len, st, fin};
			awaited_results.push_back(r);
		endfunction

		function void shift_in(logic [7:0] b);
			sum_head = sum_head + newest_b;
			newest_b = b;
			byte_cnt = byte_cnt + 7'd1;
		endfunction

		// address check first, then checksum; an accepted frame echoes its first byte
		function void close_frame();
			logic [7:0] tally, chk, calc;
			logic [1:0] st;
			ph = PH_IDLE;
			if (byte_cnt == 7'd2) begin
				tally = first_b + second_b;
				chk   = second_b;
			end else begin
				tally = sum_head;
				chk   = newest_b;
			end
			calc = 8'h00 - tally;
			if ((first_b & 8'h3F) != {3'b000, query_addr})
				st = ST_WRONG_ADDR;
			else if (calc != chk)
				st = ST_BAD_SUM;
			else
				st = ST_ACCEPTED;
			if (st != ST_ACCEPTED) begin
				if (st == ST_WRONG_ADDR)
					n_wrong_addr++;
				else
					n_bad_sum++;
				push_result(OUT_OUTCOME, 8'h00, CLASS_NONE, 8'h00, byte_cnt, st, 1'b1);
				return;
			end
			push_result(OUT_TX, first_b, CLASS_NONE, 8'h00, 7'd0, ST_ACCEPTED, 1'b0);
			if (second_b <= KEY_MAX) begin
				n_key++;
				push_result(OUT_OUTCOME, 8'h00, CLASS_KEY, 8'h00, byte_cnt, ST_ACCEPTED, 1'b1);
			end else begin
				n_typed++;
				push_result(OUT_OUTCOME, 8'h00, CLASS_TYPED, second_b, byte_cnt,
					ST_ACCEPTED, 1'b1);
			end
		endfunction

		// one accepted input transaction
		function void note_item(logic [1:0] k, logic [7:0] v, logic [4:0] a);
			logic tmo;
			tmo = (k == KIND_TIMEOUT);
			if (k == KIND_START) begin
				n_requests++;
				query_addr   = a;
				byte_cnt     = '0;
				frame_target = '0;
				first_b      = '0;
				second_b     = '0;
				sum_head     = '0;
				newest_b     = '0;
				ph           = PH_FIRST;
				push_result(OUT_TX, REQ_BYTE, CLASS_NONE, 8'h00, 7'd0, ST_ACCEPTED, 1'b0);
				push_result(OUT_TX, {3'b000, a}, CLASS_NONE, 8'h00, 7'd0, ST_ACCEPTED, 1'b1);
				return;
			end
			if (k == KIND_UNUSED || ph == PH_IDLE)
				return;
			// header bytes: a timeout here means no reply
			if (ph == PH_FIRST || ph == PH_SECOND) begin
				if (tmo) begin
					ph = PH_IDLE;
					n_no_reply++;
					push_result(OUT_OUTCOME, 8'h00, CLASS_NONE, 8'h00, 7'd0, ST_NO_REPLY, 1'b1);
					return;
				end
				if (ph == PH_FIRST) begin
					first_b  = v;
					newest_b = v;
					sum_head = '0;
					byte_cnt = 7'd1;
					ph       = PH_SECOND;
					return;
				end
				second_b = v;
				shift_in(v);
				ph = PH_BODY;
				if (v == TYPED_CODE) begin
					frame_target = FIXED_LEN;
				end else if (v <= KEY_MAX) begin
					frame_target = v[6:0] + KEY_EXTRA;
					if (v == 8'h00)
						close_frame();
				end else begin
					frame_target = '0;
				end
				return;
			end
			// open frame ends on timeout or a full buffer
			if (frame_target == 7'd0) begin
				if (tmo) begin
					close_frame();
					return;
				end
				shift_in(v);
				if (byte_cnt >= BUF_BYTES)
					close_frame();
				return;
			end
			// fixed-length frame, a timeout stands for a zero byte
			shift_in(tmo ? 8'h00 : v);
			if (byte_cnt >= frame_target)
				close_frame();
		endfunction

		task compare_field(string fname, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
					n_checked, fname, got, want));
		endtask

		task check_result(logic ok, logic [7:0] tx, logic [1:0] cls,
				logic [7:0] code, logic [6:0] len, logic [1:0] st, logic fin);
			result_t w;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0h tx %0h status %0h",
					ok, tx, st));
				return;
			end
			w = awaited_results.pop_front();
			n_checked++;
			compare_field("out_kind", 8'(ok), 8'(w.out_kind));
			compare_field("tx_byte", tx, w.tx_byte);
			compare_field("frame_class", 8'(cls), 8'(w.frame_class));
			compare_field("type_code", code, w.type_code);
			compare_field("frame_len", 8'(len), 8'(w.frame_len));
			compare_field("status", 8'(st), 8'(w.status));
			compare_field("last", 8'(fin), 8'(w.last));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] kind;
	logic [7:0] value;
	logic [4:0] target_address;
	logic       out_valid;
	logic       out_stall;
	logic       out_kind;
	logic [7:0] tx_byte;
	logic [1:0] frame_class;
	logic [7:0] type_code;
	logic [6:0] frame_len;
	logic [1:0] status;
	logic       last;

	kbfr_reply_tracker #(FRAME_BUFFER) replies;
	int unsigned quiet_cycles = 0;
	int          burst_left   = 0;
	int unsigned items_sent   = 0;
	bit          hold_req     = 1'b0;

	keypad_bus_frame_receiver_top #(
		.BUFFER_BYTES(FRAME_BUFFER)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.value         (value),
		.target_address(target_address),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_kind      (out_kind),
		.tx_byte       (tx_byte),
		.frame_class   (frame_class),
		.type_code     (type_code),
		.frame_len     (frame_len),
		.status        (status),
		.last          (last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// accepted input transactions feed the predictor
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			replies.note_item(kind, value, target_address);
	end

	// accepted results are checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			replies.check_result(out_kind, tx_byte, frame_class, type_code, frame_len,
				status, last);
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no transaction for %0d cycles, giving up", QUIET_LIMIT);
			$display("tb_keypad_bus_frame_receiver_top: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side stall patterns, plus one long hold on request
	initial begin
		stall_pattern_t pattern;
		int             left;
		out_stall = 1'b0;
		pattern   = STALL_NONE;
		left      = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				if (left == 0) begin
					pattern = stall_pattern_t'($urandom_range(0, 3));
					left    = $urandom_range(40, 200);
				end
				left--;
				case (pattern)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default:     out_stall <= (left % 3 == 0);
				endcase
			end
		end
	end

	// one input transaction, with bursts and gaps on the sender side
	task automatic send_item(input logic [1:0] k, input logic [7:0] v, input logic [4:0] a);
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		in_valid       <= 1'b1;
		kind           <= k;
		value          <= v;
		target_address <= a;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (k != KIND_UNUSED)
			items_sent++;
	endtask

	// sender pauses until every predicted result has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (replies.awaited_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// last byte becomes the checksum over all the others
	function automatic void seal_reply(ref logic [7:0] bytes[$]);
		logic [7:0] tally;
		tally = 8'h00;
		for (int i = 0; i < bytes.size() - 1; i++)
			tally = tally + bytes[i];
		bytes[bytes.size() - 1] = 8'h00 - tally;
	endfunction

	// reply bytes; zero body bytes of fixed frames may go as timeouts
	task automatic send_reply(input logic [7:0] bytes[$], input bit zero_as_timeout);
		for (int i = 0; i < bytes.size(); i++) begin
			if ($urandom_range(0, 39) == 0)
				send_item(KIND_UNUSED, 8'($urandom), 5'($urandom));
			if (zero_as_timeout && i >= 2 && bytes[i] == 8'h00 && $urandom_range(0, 1))
				send_item(KIND_TIMEOUT, 8'($urandom), 5'($urandom));
			else
				send_item(KIND_BYTE, bytes[i], 5'($urandom));
		end
	endtask

	// one request with a random reply, mostly well formed
	task automatic run_request();
		logic [4:0]   addr;
		logic [7:0]   reply[$];
		logic [7:0]   first, second;
		int           len, pick, cut;
		bit           cut_short;
		frame_style_t style;
		addr = 5'($urandom);
		send_item(KIND_START, 8'($urandom), addr);
		first      = 8'($urandom);
		first[5]   = 1'b0;
		first[4:0] = addr;
		reply      = '{first};
		cut_short  = 1'b0;
		pick = $urandom_range(0, 99);
		style = (pick < 10) ? STYLE_SILENT : (pick < 50) ? STYLE_KEY
			: (pick < 75) ? STYLE_TYPED : STYLE_OPEN;
		case (style)
			STYLE_SILENT: begin
				if ($urandom_range(0, 1))
					send_item(KIND_BYTE, first, 5'($urandom));
				send_item(KIND_TIMEOUT, 8'($urandom), 5'($urandom));
				return;
			end
			STYLE_KEY: begin
				second = 8'($urandom_range(0, 16));
				len    = int'(second) + 2;
			end
			STYLE_TYPED: begin
				second = TYPED_CODE;
				len    = int'(FIXED_LEN);
			end
			default: begin
				do second = 8'($urandom_range(17, 255)); while (second == TYPED_CODE);
				pick = $urandom_range(0, 19);
				len  = (pick == 0) ? FRAME_BUFFER
					: (pick == 1) ? $urandom_range(13, FRAME_BUFFER - 1)
					: $urandom_range(2, 12);
			end
		endcase
		reply.push_back(second);
		while (reply.size() < len)
			reply.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
		if (len >= 3)
			seal_reply(reply);
		// corrupt the address or the checksum now and then
		pick = $urandom_range(0, 99);
		if (pick < 8)
			reply[0] = reply[0] ^ 8'(1 << $urandom_range(0, 5));
		else if (pick < 16 && len >= 3)
			reply[len - 1] = reply[len - 1] ^ 8'($urandom_range(1, 255));
		// some replies stop early and the next start drops them
		if ($urandom_range(0, 24) == 0) begin
			cut       = $urandom_range(1, len - 1);
			reply     = reply[0:cut - 1];
			cut_short = 1'b1;
		end
		send_reply(reply, style != STYLE_OPEN);
		if (style == STYLE_OPEN && !cut_short && len < FRAME_BUFFER)
			send_item(KIND_TIMEOUT, 8'($urandom), 5'($urandom));
		else if (!cut_short && $urandom_range(0, 9) == 0)
			send_item($urandom_range(0, 1) ? KIND_BYTE : KIND_TIMEOUT, 8'($urandom),
				5'($urandom));
	endtask

	// main sequence
	initial begin
		logic [7:0] reply[$];
		int         n_frames;
		replies        = new();
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		kind           = KIND_START;
		value          = 8'h00;
		target_address = 5'd0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// items while idle are ignored, as is the unused kind
		send_item(KIND_BYTE, 8'hFF, 5'd31);
		send_item(KIND_TIMEOUT, 8'h00, 5'd0);
		send_item(KIND_UNUSED, 8'hA5, 5'd10);
		// timeout right after the request
		send_item(KIND_START, 8'h00, 5'd0);
		send_item(KIND_TIMEOUT, 8'hFF, 5'd31);
		// restart in the middle of a reply, then a three-byte key frame
		send_item(KIND_START, 8'hFF, 5'd7);
		send_item(KIND_BYTE, 8'hC7, 5'd0);
		send_item(KIND_START, 8'h00, 5'd5);
		reply = '{8'h05, 8'h01, 8'h00};
		seal_reply(reply);
		send_reply(reply, 1'b0);
		// two-byte key frame, both bytes summed
		send_item(KIND_START, 8'hFF, 5'd0);
		send_reply('{8'h00, 8'h00}, 1'b0);
		// typed frame at the top address, zero bytes may go as timeouts
		send_item(KIND_START, 8'h00, 5'd31);
		reply = '{8'h5F, TYPED_CODE, 8'h00, 8'h33, 8'h00, 8'h00, 8'h10, 8'hFF, 8'h00};
		seal_reply(reply);
		send_reply(reply, 1'b1);
		drain_results();

		// random requests; one long result hold and periodic drains
		n_frames = 0;
		while (items_sent < ITEM_TARGET) begin
			if (n_frames == 30)
				hold_req = 1'b1;
			if (n_frames % 60 == 59)
				drain_results();
			run_request();
			n_frames++;
		end
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (replies.awaited_results.size() != 0)
			replies.report_mismatch($sformatf("%0d predicted results never came out",
				replies.awaited_results.size()));
		$display("covered %0d requests and %0d checked results: %0d key and %0d typed frames accepted",
			replies.n_requests, replies.n_checked, replies.n_key, replies.n_typed);
		$display("rejections seen: %0d no reply, %0d wrong address, %0d bad checksum",
			replies.n_no_reply, replies.n_wrong_addr, replies.n_bad_sum);
		if (replies.mismatches == 0)
			$display("tb_keypad_bus_frame_receiver_top: PASS");
		else
			$display("tb_keypad_bus_frame_receiver_top: FAIL");
		$finish;
	end

endmodule

[keypad_bus_frame_receiver_top.f]
rtl/kbfr_pkg.sv
rtl/kbfr_framer.sv
rtl/kbfr_result_fifo.sv
rtl/keypad_bus_frame_receiver_top.sv
verif/tb_keypad_bus_frame_receiver_top.sv
